// ----- src/srf_pkg.sv -----
// Shared types, operation codes and register encodings of the system register file.
`default_nettype none

package srf_pkg;

   // Operation codes carried in the mode field.
   localparam logic [1:0] MODE_READ  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   // The register is selected by op0, op1, CRn, CRm and op2 in bits 20..5.
   localparam int SEL_LSB   = 5;
   localparam int SEL_MSB   = 20;
   localparam int SEL_WIDTH = SEL_MSB - SEL_LSB + 1;

   typedef logic [SEL_WIDTH-1:0] sel_type;

   // Encodings as {op0, op1, CRn, CRm, op2}.
   localparam sel_type ENC_CTR     = {2'd3, 3'd3, 4'd0,  4'd0, 3'd1};
   localparam sel_type ENC_MMFR0   = {2'd3, 3'd0, 4'd0,  4'd7, 3'd0};
   localparam sel_type ENC_MMFR1   = {2'd3, 3'd0, 4'd0,  4'd7, 3'd1};
   localparam sel_type ENC_SCTLR   = {2'd3, 3'd0, 4'd1,  4'd0, 3'd0};
   localparam sel_type ENC_CPACR   = {2'd3, 3'd0, 4'd1,  4'd0, 3'd2};
   localparam sel_type ENC_MDSCR   = {2'd2, 3'd0, 4'd0,  4'd2, 3'd2};
   localparam sel_type ENC_DFR0    = {2'd3, 3'd0, 4'd0,  4'd5, 3'd0};
   localparam sel_type ENC_MAIR    = {2'd3, 3'd0, 4'd10, 4'd2, 3'd0};
   localparam sel_type ENC_TCR     = {2'd3, 3'd0, 4'd2,  4'd0, 3'd2};
   localparam sel_type ENC_CNTPCT  = {2'd3, 3'd3, 4'd14, 4'd0, 3'd1};
   localparam sel_type ENC_CNTVOFF = {2'd3, 3'd4, 4'd14, 4'd0, 3'd3};
   localparam sel_type ENC_CNTVCT  = {2'd3, 3'd3, 4'd14, 4'd0, 3'd2};
   localparam sel_type ENC_TPIDR0  = {2'd3, 3'd3, 4'd13, 4'd0, 3'd2};
   localparam sel_type ENC_TPIDR1  = {2'd3, 3'd0, 4'd13, 4'd0, 3'd4};
   localparam sel_type ENC_MPIDR   = {2'd3, 3'd0, 4'd0,  4'd0, 3'd5};
   localparam sel_type ENC_DCZID   = {2'd3, 3'd3, 4'd0,  4'd0, 3'd7};
   localparam sel_type ENC_SPEL0   = {2'd3, 3'd0, 4'd4,  4'd1, 3'd0};
   localparam sel_type ENC_VBAR1   = {2'd3, 3'd0, 4'd12, 4'd0, 3'd0};

   // Fixed identification values.
   localparam logic [63:0] VAL_CTR   = 64'h0000_0000_0444_c004;
   localparam logic [63:0] VAL_MMFR0 = 64'h0000_0000_0010_0000;
   localparam logic [63:0] VAL_DFR0  = 64'h0000_0000_1010_1006;
   localparam logic [63:0] VAL_MPIDR = 64'h0000_0000_4000_0000;

   // Status codes.
   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   // One input word.
   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] access_word;
      logic [63:0] write_data;
   } req_type;

   // One result word.
   typedef struct packed {
      logic [63:0] read_data;
      logic        status;
      logic        mmu_enable;
   } rsp_type;

endpackage

`default_nettype wire

// ----- src/srf_exec.sv -----
// Register state, access decode and read selection of the system register file.
`default_nettype none

module srf_exec
   import srf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    exec_en,
   input  wire req_type req,
   output rsp_type      result
);

   logic [63:0] control_ff, control_in;
   logic [63:0] cpacr_ff, cpacr_in;
   logic [63:0] mdscr_ff, mdscr_in;
   logic [63:0] mair_ff, mair_in;
   logic [63:0] tcr_ff, tcr_in;
   logic [63:0] cntvoff_ff, cntvoff_in;
   logic [63:0] tpidr0_ff, tpidr0_in;
   logic [63:0] tpidr1_ff, tpidr1_in;
   logic [63:0] spel0_ff, spel0_in;
   logic [63:0] vbar_ff, vbar_in;
   logic [63:0] tick_ff, tick_in;

   sel_type     sel;
   logic [63:0] rd_value;
   logic        rd_known;
   logic        wr_known;
   logic        is_read;
   logic        is_write;
   logic        is_tick;

   assign sel      = req.access_word[SEL_MSB:SEL_LSB];
   assign is_read  = (req.mode == MODE_READ);
   assign is_write = (req.mode == MODE_WRITE);
   assign is_tick  = (req.mode == MODE_TICK);

   // Read selection, including the virtual counter difference.
   always_comb begin
      rd_known = 1'b1;
      case (sel)
         ENC_CTR:     rd_value = VAL_CTR;
         ENC_MMFR0:   rd_value = VAL_MMFR0;
         ENC_MMFR1:   rd_value = '0;
         ENC_SCTLR:   rd_value = control_ff;
         ENC_CPACR:   rd_value = cpacr_ff;
         ENC_MDSCR:   rd_value = mdscr_ff;
         ENC_DFR0:    rd_value = VAL_DFR0;
         ENC_MAIR:    rd_value = mair_ff;
         ENC_TCR:     rd_value = tcr_ff;
         ENC_CNTPCT:  rd_value = tick_ff;
         ENC_CNTVOFF: rd_value = cntvoff_ff;
         ENC_CNTVCT:  rd_value = tick_ff - cntvoff_ff;
         ENC_TPIDR0:  rd_value = tpidr0_ff;
         ENC_TPIDR1:  rd_value = tpidr1_ff;
         ENC_MPIDR:   rd_value = VAL_MPIDR;
         ENC_DCZID:   rd_value = '0;
         ENC_SPEL0:   rd_value = spel0_ff;
         ENC_VBAR1:   rd_value = vbar_ff;
         default: begin
            rd_value = '0;
            rd_known = 1'b0;
         end
      endcase
   end

   // Write decode; fixed values and counters are not writable.
   always_comb begin
      control_in = control_ff;
      cpacr_in   = cpacr_ff;
      mdscr_in   = mdscr_ff;
      mair_in    = mair_ff;
      tcr_in     = tcr_ff;
      cntvoff_in = cntvoff_ff;
      tpidr0_in  = tpidr0_ff;
      tpidr1_in  = tpidr1_ff;
      spel0_in   = spel0_ff;
      vbar_in    = vbar_ff;
      wr_known   = 1'b1;
      case (sel)
         ENC_SCTLR:   control_in = req.write_data;
         ENC_CPACR:   cpacr_in   = req.write_data;
         ENC_MDSCR:   mdscr_in   = req.write_data;
         ENC_MAIR:    mair_in    = req.write_data;
         ENC_TCR:     tcr_in     = req.write_data;
         ENC_CNTVOFF: cntvoff_in = req.write_data;
         ENC_TPIDR0:  tpidr0_in  = req.write_data;
         ENC_TPIDR1:  tpidr1_in  = req.write_data;
         ENC_SPEL0:   spel0_in   = req.write_data;
         ENC_VBAR1:   vbar_in    = req.write_data;
         default:     wr_known   = 1'b0;
      endcase
   end

   assign tick_in = tick_ff + 64'd1;

   // Result word; the MMU enable reflects the control register after this word.
   always_comb begin
      result.read_data  = (is_read && rd_known) ? rd_value : '0;
      result.status     = STATUS_DONE;
      result.mmu_enable = control_ff[0];
      if (is_read) begin
         if (!rd_known) begin
            result.status = STATUS_ERROR;
         end
      end else if (is_write) begin
         if (wr_known) begin
            result.mmu_enable = control_in[0];
         end else begin
            result.status = STATUS_ERROR;
         end
      end else if (!is_tick) begin
         result.status = STATUS_ERROR;
      end
   end

   // State update when a word executes.
   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff <= '0;
         cpacr_ff   <= '0;
         mdscr_ff   <= '0;
         mair_ff    <= '0;
         tcr_ff     <= '0;
         cntvoff_ff <= '0;
         tpidr0_ff  <= '0;
         tpidr1_ff  <= '0;
         spel0_ff   <= '0;
         vbar_ff    <= '0;
         tick_ff    <= '0;
      end else if (exec_en) begin
         if (is_write) begin
            control_ff <= control_in;
            cpacr_ff   <= cpacr_in;
            mdscr_ff   <= mdscr_in;
            mair_ff    <= mair_in;
            tcr_ff     <= tcr_in;
            cntvoff_ff <= cntvoff_in;
            tpidr0_ff  <= tpidr0_in;
            tpidr1_ff  <= tpidr1_in;
            spel0_ff   <= spel0_in;
            vbar_ff    <= vbar_in;
         end
         if (is_tick) begin
            tick_ff <= tick_in;
         end
      end
   end

`ifndef ASSERT_OFF
   // A tick advances the physical counter by exactly one.
   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      (exec_en && is_tick) |=> (tick_ff == $past(tick_ff) + 64'd1))
      else $error("tick counter did not advance by one");

   // The reported MMU enable matches the control register after the word.
   a_mmu_match: assert property (@(posedge clock) disable iff (reset)
      exec_en |=> (control_ff[0] == $past(result.mmu_enable)))
      else $error("mmu enable disagrees with control register");
`endif

endmodule

`default_nettype wire

// ----- src/system_register_file.sv -----
// Top level of the system register file: input register, execute logic, result register.
//
// Usage:
//   Request words (req_mode, req_access_word, req_write_data) are accepted on a
//   rising edge with req_valid high and req_stall low. Mode read returns the
//   selected register, mode write stores req_write_data, mode tick advances the
//   physical counter. Bits 20..5 of the access word select the register.
//   Each request gives exactly one response word on rsp_read_data, rsp_status
//   and rsp_mmu_enable, taken when rsp_valid is high and rsp_stall is low.
// Pipeline and throughput:
//   A word is registered at the input and executed against the register state
//   once the output register can load. Its response then loads into the output
//   register, which drives rsp_valid. One word per cycle is sustained while
//   rsp_stall is low, and a word sees every effect of the word before it.
// Reset:
//   Synchronous reset clears all registers and the counter, and empties both
//   pipeline registers.
// Stall:
//   When rsp_stall holds a full output register, the input register holds too
//   and req_stall rises once it is full; no word is lost or executed twice.
`default_nettype none

module system_register_file
   import srf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [31:0] req_access_word,
   input  wire logic [63:0] req_write_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_read_data,
   output logic             rsp_status,
   output logic             rsp_mmu_enable
);

   logic    in_valid_ff, in_valid_in;
   req_type in_word_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_word_ff;
   rsp_type exec_result;
   logic    exec_en;
   logic    req_take;

   // Execute when the input register is full and the output register can load.
   assign exec_en   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !exec_en;
   assign req_take  = req_valid && !req_stall;

   srf_exec u_exec (
      .clock   (clock),
      .reset   (reset),
      .exec_en (exec_en),
      .req     (in_word_ff),
      .result  (exec_result)
   );

   // Pipeline occupancy.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (exec_en) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (exec_en) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff.mode        <= req_mode;
         in_word_ff.access_word <= req_access_word;
         in_word_ff.write_data  <= req_write_data;
      end
      if (exec_en) begin
         out_word_ff <= exec_result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_read_data  = out_word_ff.read_data;
   assign rsp_status     = out_word_ff.status;
   assign rsp_mmu_enable = out_word_ff.mmu_enable;

`ifndef ASSERT_OFF
   // A full input register behind a stalled full output register must stall.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && rsp_stall) |-> req_stall)
      else $error("input not stalled behind a blocked response");

   // An error response never carries read data.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_ERROR) |-> (rsp_read_data == 64'd0))
      else $error("error response with nonzero data");
`endif

endmodule

`default_nettype wire

// ----- test/system_register_file_tb.sv -----
// Testbench of the system register file: directed and random accesses checked against a predictor.
`timescale 1ns / 100ps

module system_register_file_tb;
   import srf_pkg::*;

   // The fourth mode value has no operation behind it.
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [31:0] SEL_FIELD =
      {{(31-SEL_MSB){1'b0}}, {SEL_WIDTH{1'b1}}, {SEL_LSB{1'b0}}};
   localparam int RANDOM_WORDS  = 1525;
   localparam int WATCHDOG_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = MODE_READ;
   logic [31:0] req_access_word = '0;
   logic [63:0] req_write_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_read_data;
   logic        rsp_status;
   logic        rsp_mmu_enable;

   // Words waiting to be sent, and responses predicted for accepted words.
   req_type access_words_q [$];
   rsp_type access_results_q [$];
   int      drain_points_q [$];

   int words_sent = 0;
   int words_taken = 0;
   int total_words = 0;
   int phase1_start = 0;
   int phase2_start = 0;
   int error_count = 0;
   int quiet_cycles = 0;

   // Predicted register state.
   logic [63:0] sctlr_q, cpacr_q, mdscr_q, mair_q, tcr_q, cntvoff_q;
   logic [63:0] tpidr0_q, tpidr1_q, sp_el0_q, vbar_q, ticks_q;

   sel_type known_sel [18] = '{ENC_CTR, ENC_MMFR0, ENC_MMFR1, ENC_SCTLR, ENC_CPACR,
                               ENC_MDSCR, ENC_DFR0, ENC_MAIR, ENC_TCR, ENC_CNTPCT,
                               ENC_CNTVOFF, ENC_CNTVCT, ENC_TPIDR0, ENC_TPIDR1,
                               ENC_MPIDR, ENC_DCZID, ENC_SPEL0, ENC_VBAR1};

   system_register_file i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_access_word (req_access_word),
      .req_write_data  (req_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_data   (rsp_read_data),
      .rsp_status      (rsp_status),
      .rsp_mmu_enable  (rsp_mmu_enable)
   );

   always #6 clock = ~clock;

   // Builds one access word; bits outside the select field come from noise.
   function automatic req_type make_word(input logic [1:0] mode, input sel_type sel,
                                         input logic [31:0] noise, input logic [63:0] data);
      req_type w;
      w.mode = mode;
      w.access_word = noise & ~SEL_FIELD;
      w.access_word[SEL_MSB:SEL_LSB] = sel;
      w.write_data = data;
      return w;
   endfunction

   // Executes one access against the predicted state and returns its response.
   function automatic rsp_type execute_access(input req_type w);
      rsp_type r;
      sel_type sel;
      sel = w.access_word[SEL_MSB:SEL_LSB];
      r.read_data = '0;
      r.status = STATUS_DONE;
      case (w.mode)
         MODE_READ: begin
            case (sel)
               ENC_CTR:     r.read_data = VAL_CTR;
               ENC_MMFR0:   r.read_data = VAL_MMFR0;
               ENC_MMFR1:   r.read_data = '0;
               ENC_SCTLR:   r.read_data = sctlr_q;
               ENC_CPACR:   r.read_data = cpacr_q;
               ENC_MDSCR:   r.read_data = mdscr_q;
               ENC_DFR0:    r.read_data = VAL_DFR0;
               ENC_MAIR:    r.read_data = mair_q;
               ENC_TCR:     r.read_data = tcr_q;
               ENC_CNTPCT:  r.read_data = ticks_q;
               ENC_CNTVOFF: r.read_data = cntvoff_q;
               ENC_CNTVCT:  r.read_data = ticks_q - cntvoff_q;
               ENC_TPIDR0:  r.read_data = tpidr0_q;
               ENC_TPIDR1:  r.read_data = tpidr1_q;
               ENC_MPIDR:   r.read_data = VAL_MPIDR;
               ENC_DCZID:   r.read_data = '0;
               ENC_SPEL0:   r.read_data = sp_el0_q;
               ENC_VBAR1:   r.read_data = vbar_q;
               default:     r.status = STATUS_ERROR;
            endcase
         end
         MODE_WRITE: begin
            // ID values and counters are not writable and answer an error.
            case (sel)
               ENC_SCTLR:   sctlr_q = w.write_data;
               ENC_CPACR:   cpacr_q = w.write_data;
               ENC_MDSCR:   mdscr_q = w.write_data;
               ENC_MAIR:    mair_q = w.write_data;
               ENC_TCR:     tcr_q = w.write_data;
               ENC_CNTVOFF: cntvoff_q = w.write_data;
               ENC_TPIDR0:  tpidr0_q = w.write_data;
               ENC_TPIDR1:  tpidr1_q = w.write_data;
               ENC_SPEL0:   sp_el0_q = w.write_data;
               ENC_VBAR1:   vbar_q = w.write_data;
               default:     r.status = STATUS_ERROR;
            endcase
         end
         MODE_TICK: ticks_q = ticks_q + 64'd1;
         default:   r.status = STATUS_ERROR;
      endcase
      r.mmu_enable = sctlr_q[0];
      return r;
   endfunction

   // Drives the request channel and the response stall on the falling edge.
   always @(negedge clock) begin : driver
      req_type w;
      int phase;
      int send_idle_pct;
      int recv_idle_pct;
      logic hold;
      phase = (words_sent < phase1_start) ? 0 : (words_sent < phase2_start) ? 1 : 2;
      send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 65 : 0;
      recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 34 : 0;
      if (!reset) begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         // At a drain point the sender waits until every response is back.
         hold = 1'b0;
         if (drain_points_q.size() != 0 && words_sent == drain_points_q[0]) begin
            hold = 1'b1;
            if (access_results_q.size() == 0 && words_taken == words_sent) begin
               void'(drain_points_q.pop_front());
            end
         end
         if (!(req_valid && words_taken < words_sent)) begin
            if (access_words_q.size() == 0 || hold || $urandom_range(99) < send_idle_pct) begin
               req_valid <= 1'b0;
            end else begin
               w = access_words_q.pop_front();
               req_valid <= 1'b1;
               req_mode <= w.mode;
               req_access_word <= w.access_word;
               req_write_data <= w.write_data;
               words_sent++;
            end
         end
      end
   end

   // Checks each response word and predicts the response of each accepted request.
   always @(posedge clock) begin : monitor
      rsp_type got;
      rsp_type want;
      logic moved;
      if (reset) begin
         sctlr_q = '0;   cpacr_q = '0;  mdscr_q = '0;  mair_q = '0;   tcr_q = '0;
         cntvoff_q = '0; tpidr0_q = '0; tpidr1_q = '0; sp_el0_q = '0; vbar_q = '0;
         ticks_q = '0;
      end else begin
         moved = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            got = {rsp_read_data, rsp_status, rsp_mmu_enable};
            if (access_results_q.size() == 0) begin
               $error("response word with no request outstanding");
               error_count++;
            end else begin
               want = access_results_q.pop_front();
               if (got.read_data !== want.read_data) begin
                  $error("read_data mismatch: expected %h, actual %h",
                         want.read_data, got.read_data);
                  error_count++;
               end
               if (got.status !== want.status) begin
                  $error("status mismatch: expected %b, actual %b", want.status, got.status);
                  error_count++;
               end
               if (got.mmu_enable !== want.mmu_enable) begin
                  $error("mmu_enable mismatch: expected %b, actual %b",
                         want.mmu_enable, got.mmu_enable);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            access_results_q.push_back(
               execute_access({req_mode, req_access_word, req_write_data}));
            words_taken++;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   // Ends the run when nothing moves on either channel for too long.
   initial begin : watchdog
      while (quiet_cycles < WATCHDOG_LIMIT) @(negedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      int pick;
      logic [1:0] m;
      sel_type s;
      logic [63:0] d;

      // Directed words: control bit, counters and offset wrap, ID values, errors.
      access_words_q.push_back(make_word(MODE_READ,  ENC_SCTLR,  32'h0, 64'h0));
      access_words_q.push_back(make_word(MODE_WRITE, ENC_SCTLR,  32'h0, '1));
      access_words_q.push_back(make_word(MODE_READ,  ENC_SCTLR,  32'h0, 64'h0));
      access_words_q.push_back(make_word(MODE_WRITE, ENC_SCTLR,  32'h0,
                                         64'hffff_ffff_ffff_fffe));
      access_words_q.push_back(make_word(MODE_TICK,  '0,         32'h0, 64'h0));
      access_words_q.push_back(make_word(MODE_WRITE, ENC_CNTVOFF, 32'h0, 64'd2));
      access_words_q.push_back(make_word(MODE_READ,  ENC_CNTVCT, 32'h0, 64'h0));
      access_words_q.push_back(make_word(MODE_READ,  ENC_CNTPCT, 32'h0, 64'h0));
      access_words_q.push_back(make_word(MODE_READ,  ENC_CTR,    32'h0, 64'h0));
      access_words_q.push_back(make_word(MODE_READ,  ENC_MMFR0,  32'h0, 64'h0));
      access_words_q.push_back(make_word(MODE_READ,  ENC_MMFR1,  32'h0, 64'h0));
      access_words_q.push_back(make_word(MODE_READ,  ENC_DFR0,   32'h0, 64'h0));
      access_words_q.push_back(make_word(MODE_READ,  ENC_MPIDR,  32'h0, 64'h0));
      access_words_q.push_back(make_word(MODE_READ,  ENC_DCZID,  32'h0, 64'h0));
      access_words_q.push_back(make_word(MODE_WRITE, ENC_CTR,    32'h0, '1));
      access_words_q.push_back(make_word(MODE_WRITE, ENC_CNTPCT, 32'h0, '1));
      access_words_q.push_back(make_word(MODE_READ,  '0,         32'h0, 64'h0));
      access_words_q.push_back(make_word(MODE_UNUSED, '1,        '1,    '1));
      access_words_q.push_back(make_word(MODE_READ,  ENC_VBAR1,  '1,    64'h0));
      access_words_q.push_back(make_word(MODE_WRITE, ENC_VBAR1,  '1,    '1));
      access_words_q.push_back(make_word(MODE_READ,  ENC_VBAR1,  '1,    64'h0));
      access_words_q.push_back(make_word(MODE_WRITE, ENC_TPIDR0, 32'h0,
                                         64'h8000_0000_0000_0001));
      access_words_q.push_back(make_word(MODE_READ,  ENC_TPIDR0, 32'h0, 64'h0));
      access_words_q.push_back(make_word(MODE_TICK,  '1,         '1,    '1));
      access_words_q.push_back(make_word(MODE_WRITE, '1,         '1,    '1));

      // Phase boundaries double as points where the sender drains the block.
      phase1_start = access_words_q.size() + RANDOM_WORDS / 3;
      phase2_start = phase1_start + RANDOM_WORDS / 3;
      drain_points_q.push_back(access_words_q.size());
      drain_points_q.push_back(phase1_start);
      drain_points_q.push_back(phase2_start);

      // Random words: mostly known encodings, with noise in the unused bits.
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         pick = $urandom_range(99);
         m = (pick < 40) ? MODE_READ : (pick < 75) ? MODE_WRITE :
             (pick < 97) ? MODE_TICK : MODE_UNUSED;
         s = ($urandom_range(99) < 85) ? known_sel[$urandom_range(17)] : sel_type'($urandom);
         pick = $urandom_range(99);
         d = (pick < 10) ? 64'h0 : (pick < 20) ? '1 :
             (pick < 30) ? 64'($urandom_range(15)) : {$urandom, $urandom};
         access_words_q.push_back(make_word(m, s, $urandom, d));
      end
      total_words = access_words_q.size();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every response, then keep watching for any stray word.
      while (!(words_taken == total_words && access_results_q.size() == 0)) @(negedge clock);
      repeat (8) @(negedge clock);
      if (error_count == 0 && access_results_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
